/* sv/fpdq_pkg.sv */
`default_nettype none

package fpdq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned HISTORY_DEPTH_DEF = 8;

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned RATE_W   = 8;

  // apb register file
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;
  localparam logic        REG_IDX_STREAM_FPS  = 1'b0;
  localparam logic        REG_IDX_DISPLAY_HZ  = 1'b1;
  localparam logic [RATE_W-1:0] STREAM_FPS_RESET = 8'd60;
  localparam logic [RATE_W-1:0] DISPLAY_HZ_RESET = 8'd0;

  // pacing constants
  localparam int unsigned TARGET_LO      = 1;
  localparam int unsigned TARGET_HI      = 3;
  localparam int unsigned HIST_LOW_MARK  = 1;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_VSYNC  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_DROPPED   = 3'd0,
    KIND_PRESENTED = 3'd1,
    KIND_NONE      = 3'd2,
    KIND_ACCEPTED  = 3'd3,
    KIND_REJECTED  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUBMIT,
    ST_SCAN,
    ST_POP
  } state_e;

  typedef struct packed {
    logic done;
    logic target_hi;
  } hist_sts_t;

endpackage

`default_nettype wire

/* sv/fpdq_chan_if.sv */
`default_nettype none

interface fpdq_in_if import fpdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [HANDLE_W-1:0] frame_handle;

  modport source (output valid, command, frame_handle, input ready);
  modport sink   (input valid, command, frame_handle, output ready);
endinterface

interface fpdq_out_if import fpdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   result_kind;
  logic [HANDLE_W-1:0] out_handle;
  logic                last_of_run;

  modport source (output valid, result_kind, out_handle, last_of_run, input ready);
  modport sink   (input valid, result_kind, out_handle, last_of_run, output ready);
endinterface

`default_nettype wire

/* sv/fpdq_slot_ram.sv */
`default_nettype none

module fpdq_slot_ram import fpdq_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned WIDTH = HANDLE_W
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/fpdq_hist.sv */
`default_nettype none

module fpdq_hist import fpdq_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned LEN_W         = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [LEN_W-1:0] qlen_i,
  output hist_sts_t             sts_o
);

  localparam int unsigned HIW = $clog2(HISTORY_DEPTH);
  localparam int unsigned HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HSW = HIW + 1;

  logic [LEN_W-1:0] len_q [HISTORY_DEPTH];
  logic [HIW-1:0]   hhead_q;
  logic [HCW-1:0]   hcount_q;
  logic [HCW-1:0]   idx_q;
  logic             busy_q;
  logic             flag_q;

  logic [HSW-1:0] rd_sum, wr_sum;
  logic [HIW-1:0] rd_addr, tail_addr, wr_addr, hhead_inc;
  logic           scan_end, full;

  // ring index, sum stays below twice the depth
  assign rd_sum    = HSW'(hhead_q) + HSW'(idx_q);
  assign rd_addr   = (rd_sum >= HSW'(HISTORY_DEPTH)) ? HIW'(rd_sum - HSW'(HISTORY_DEPTH))
                                                     : HIW'(rd_sum);
  assign wr_sum    = HSW'(hhead_q) + HSW'(hcount_q);
  assign tail_addr = (wr_sum >= HSW'(HISTORY_DEPTH)) ? HIW'(wr_sum - HSW'(HISTORY_DEPTH))
                                                     : HIW'(wr_sum);
  assign hhead_inc = (hhead_q == HIW'(HISTORY_DEPTH - 1)) ? '0 : hhead_q + 1'b1;

  assign full     = (hcount_q == HCW'(HISTORY_DEPTH));
  assign scan_end = busy_q && (idx_q == hcount_q);
  // when full the evicted slot is the one that takes the new length
  assign wr_addr  = full ? hhead_q : tail_addr;

  always_ff @(posedge clk_i) begin
    if (scan_end) begin
      len_q[wr_addr] <= qlen_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hhead_q  <= '0;
      hcount_q <= '0;
      idx_q    <= '0;
      busy_q   <= 1'b0;
      flag_q   <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      flag_q <= 1'b0;
    end else if (busy_q) begin
      if (scan_end) begin
        busy_q <= 1'b0;
        if (full) begin
          hhead_q <= hhead_inc;
        end else begin
          hcount_q <= hcount_q + 1'b1;
        end
      end else begin
        flag_q <= flag_q | (len_q[rd_addr] <= LEN_W'(HIST_LOW_MARK));
        idx_q  <= idx_q + 1'b1;
      end
    end
  end

  assign sts_o.done      = scan_end;
  assign sts_o.target_hi = flag_q;

endmodule

`default_nettype wire

/* sv/frame_pacing_drop_queue.sv */
// frame_pacing_drop_queue: vsync paced queue of frame handles
//
// in_i (sink) takes requests: command 0 submits frame_handle, command 1 is a
// vsync tick. out_o (source) returns results: result_kind, out_handle and
// last_of_run, which marks the final result of one request. an apb port sets
// stream_max_fps (0x0) and display_refresh_hz (0x4); pready is always high.
//
// one request at a time: in_i.ready is high only while the sequencer idles.
// a submit passes through the submit state and its result goes into the
// output register. a vsync scans the stored history lengths, one stored
// length compared per cycle by a single compare unit (no scan when the
// stream rate is below the display rate), then emits its results. drops
// come one a cycle unless the output stalls, the slot memory reads ahead
// at the next head.
// results go through one output register; a stalled receiver holds the
// sequencer in place until the register frees up, nothing is lost.
// reset empties the queue and history and loads the register defaults;
// stored handles and lengths are not cleared and need no clearing pass.
`default_nettype none

module frame_pacing_drop_queue import fpdq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  fpdq_in_if.sink                in_i,
  fpdq_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = IW + 1;

  // configuration registers
  logic [RATE_W-1:0] fps_q, hz_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q <= STREAM_FPS_RESET;
      hz_q  <= DISPLAY_HZ_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IDX_STREAM_FPS: fps_q <= pwdata[RATE_W-1:0];
        REG_IDX_DISPLAY_HZ: hz_q  <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_STREAM_FPS: prdata = APB_DW'(fps_q);
      REG_IDX_DISPLAY_HZ: prdata = APB_DW'(hz_q);
      default:            prdata = '0;
    endcase
  end

  // sequencer and queue state
  state_e              state_q, state_d;
  logic [IW-1:0]       head_q, head_d, head_inc, tail;
  logic [CW-1:0]       count_q, count_d, target;
  logic [HANDLE_W-1:0] hdl_q;
  logic                tgt_hi_q;
  logic [SW-1:0]       tail_sum;

  logic [HANDLE_W-1:0] slot_rdata;
  hist_sts_t           hist_sts;

  logic                in_fire, use_hist, out_free, full;
  logic                emit, emit_last, slot_we, pop, hist_start;
  kind_e               emit_kind;
  logic [HANDLE_W-1:0] emit_handle;

  // output register
  logic                out_valid_q;
  kind_e               out_kind_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic                out_last_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign use_hist   = (fps_q >= hz_q);
  assign out_free   = !out_valid_q || out_o.ready;
  assign full       = (count_q == CW'(QUEUE_DEPTH));
  assign target     = tgt_hi_q ? CW'(TARGET_HI) : CW'(TARGET_LO);

  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? IW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : IW'(tail_sum);
  assign head_inc = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.command == CMD_VSYNC) ? ST_SCAN : ST_SUBMIT;
        end
      end
      ST_SUBMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (!use_hist || hist_sts.done) state_d = ST_POP;
      end
      ST_POP: begin
        // stays while dropping
        if (out_free && (count_q <= target)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    emit        = 1'b0;
    emit_kind   = KIND_NONE;
    emit_handle = '0;
    emit_last   = 1'b0;
    slot_we     = 1'b0;
    pop         = 1'b0;
    hist_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        hist_start = in_fire && (in_i.command == CMD_VSYNC) && use_hist;
      end
      ST_SUBMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (full) begin
            emit_kind   = KIND_REJECTED;
            emit_handle = hdl_q;
          end else begin
            emit_kind = KIND_ACCEPTED;
            slot_we   = 1'b1;
          end
        end
      end
      ST_SCAN: ;
      ST_POP: begin
        if (out_free) begin
          emit = 1'b1;
          priority if (count_q == '0) begin
            emit_kind = KIND_NONE;
            emit_last = 1'b1;
          end else if (count_q > target) begin
            emit_kind   = KIND_DROPPED;
            emit_handle = slot_rdata;
            pop         = 1'b1;
          end else begin
            emit_kind   = KIND_PRESENTED;
            emit_handle = slot_rdata;
            emit_last   = 1'b1;
            pop         = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign head_d  = pop ? head_inc : head_q;
  assign count_d = slot_we ? count_q + 1'b1 : (pop ? count_q - 1'b1 : count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      tgt_hi_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (in_fire) begin
        tgt_hi_q <= 1'b0;
      end else if (state_q == ST_SCAN && hist_sts.done) begin
        tgt_hi_q <= hist_sts.target_hi;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hdl_q <= in_i.frame_handle;
    end
    if (emit) begin
      out_kind_q   <= emit_kind;
      out_handle_q <= emit_handle;
      out_last_q   <= emit_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.out_handle  = out_handle_q;
  assign out_o.last_of_run = out_last_q;

  // slot memory reads ahead at the next head so drops run one a cycle unless stalled
  fpdq_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (HANDLE_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (tail),
    .wdata_i (hdl_q),
    .raddr_i (head_d),
    .rdata_o (slot_rdata)
  );

  fpdq_hist #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .LEN_W         (CW)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hist_start),
    .qlen_i  (count_q),
    .sts_o   (hist_sts)
  );

endmodule

`default_nettype wire

/* tb/frame_pacing_drop_queue_tb.sv */
`default_nettype none

module frame_pacing_drop_queue_tb;
  import fpdq_pkg::*;

  // slot and history pointers wrap at the (power of two) depths
  localparam int unsigned SLOT_AW = $clog2(QUEUE_DEPTH_DEF);
  localparam int unsigned HIST_AW = $clog2(HISTORY_DEPTH_DEF);
  // longest vsync: full history scan plus all of its results, with margin
  localparam int unsigned SETTLE_CYCLES = HISTORY_DEPTH_DEF + QUEUE_DEPTH_DEF + 3;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 42;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    kind_e               kind;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } pacing_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fpdq_in_if  in_if ();
  fpdq_out_if out_if ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  frame_pacing_drop_queue uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the queue, the length history and the
  // two rate registers, advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic [HANDLE_W-1:0] frame_slots [QUEUE_DEPTH_DEF];
  logic [SLOT_AW-1:0]  q_head = '0;
  logic [SLOT_AW:0]    q_count = '0;
  logic [SLOT_AW:0]    hist_len [HISTORY_DEPTH_DEF];
  logic [HIST_AW-1:0]  hist_head = '0;
  logic [HIST_AW:0]    hist_count = '0;
  logic [RATE_W-1:0]   cfg_stream_fps = STREAM_FPS_RESET;
  logic [RATE_W-1:0]   cfg_display_hz = DISPLAY_HZ_RESET;

  // results still owed by the block, oldest first
  pacing_result_t expected_results [$];

  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void push_result(kind_e kind, logic [HANDLE_W-1:0] handle);
    pacing_result_t r;
    r.kind = kind;
    r.handle = handle;
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic logic [HANDLE_W-1:0] pop_oldest_frame();
    logic [HANDLE_W-1:0] h;
    h = frame_slots[q_head];
    q_head = q_head + 1'b1;
    q_count = q_count - 1'b1;
    return h;
  endfunction

  // expected results of one request, the final one flagged as last of run
  function automatic void predict_request(logic cmd, logic [HANDLE_W-1:0] handle);
    int unsigned    target;
    pacing_result_t tail;
    if (cmd == CMD_SUBMIT) begin
      if (q_count >= QUEUE_DEPTH_DEF) begin
        push_result(KIND_REJECTED, handle);
      end else begin
        frame_slots[SLOT_AW'(q_head + q_count)] = handle;
        q_count = q_count + 1'b1;
        push_result(KIND_ACCEPTED, '0);
      end
    end else begin
      target = TARGET_LO;
      // history only counts while the stream can keep up with the display
      if (cfg_stream_fps >= cfg_display_hz) begin
        for (int i = 0; i < hist_count; i++) begin
          if (hist_len[HIST_AW'(hist_head + i)] <= HIST_LOW_MARK) target = TARGET_HI;
        end
        if (hist_count >= HISTORY_DEPTH_DEF) begin
          hist_head = hist_head + 1'b1;
          hist_count = (HIST_AW + 1)'(HISTORY_DEPTH_DEF - 1);
        end
        hist_len[HIST_AW'(hist_head + hist_count)] = q_count;
        hist_count = hist_count + 1'b1;
      end
      while (q_count > target) push_result(KIND_DROPPED, pop_oldest_frame());
      if (q_count == 0) begin
        push_result(KIND_NONE, '0);
      end else begin
        push_result(KIND_PRESENTED, pop_oldest_frame());
      end
    end
    tail = expected_results.pop_back();
    tail.last = 1'b1;
    expected_results.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every accepted result is matched against the oldest
  // expectation, values sampled at the edge before any update lands
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    pacing_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected result: kind %0d handle %h last %0b",
                             out_if.result_kind, out_if.out_handle, out_if.last_of_run));
      end else begin
        want = expected_results.pop_front();
        if (out_if.result_kind !== want.kind || out_if.out_handle !== want.handle ||
            out_if.last_of_run !== want.last) begin
          flag_error($sformatf({"result mismatch: kind %0d/%0d handle %h/%h ",
                                "last %0b/%0b (expected/actual)"},
                               want.kind, out_if.result_kind, want.handle,
                               out_if.out_handle, want.last, out_if.last_of_run));
        end
      end
    end
  end

  // receiver side: random back-pressure, one new ready value per edge
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog: any request or result handshake counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // request driver: optional idle cycles first, then hold valid until accepted
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic cmd, input logic [HANDLE_W-1:0] handle);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.frame_handle <= handle;
    do @(posedge clk_i); while (!in_if.ready);
    predict_request(cmd, handle);
  endtask

  // sender holds off until every owed result is back, then lets the
  // sequencer settle so the block is idle
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write followed by a read back of the same register
  task automatic write_rate_reg(input logic idx, input logic [RATE_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_IDX_STREAM_FPS) begin
      cfg_stream_fps = value;
    end else begin
      cfg_display_hz = value;
    end
    // back-to-back read setup, psel stays high
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[RATE_W-1:0] !== value) begin
      flag_error($sformatf("register %0d read back %h, wrote %h", idx,
                           prdata[RATE_W-1:0], value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // directed: vsync on an empty queue, fill with corner handles, overflow,
  // then vsyncs that drop down to the high target and present the rest
  // ---------------------------------------------------------------------------
  task automatic test_directed_queue();
    logic [HANDLE_W-1:0] corner_handles [4];
    corner_handles = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
    // nothing to present, history gets a zero length
    send_request(CMD_VSYNC, 16'hFFFF);
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
      send_request(CMD_SUBMIT, (i < 4) ? corner_handles[i] :
                               HANDLE_W'($urandom_range(0, 65535)));
    end
    // queue full: both rejected with their handle
    send_request(CMD_SUBMIT, 16'hFFFF);
    send_request(CMD_SUBMIT, 16'h0000);
    // short history entry forces target 3: a long drop run
    send_request(CMD_VSYNC, 16'h0000);
    send_request(CMD_VSYNC, 16'h5555);
    send_request(CMD_VSYNC, 16'hAAAA);
    send_request(CMD_VSYNC, 16'h1234);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic over several rate settings and idling mixes; mostly submit
  // bursts closed by a vsync, sometimes long enough to overflow, plus noise
  // ---------------------------------------------------------------------------
  task automatic test_rate_regimes();
    int unsigned fps_set [6];
    int unsigned hz_set [6];
    int unsigned idle_set [4];
    int unsigned stall_set [4];
    int unsigned sent;
    int unsigned burst;
    logic [RATE_W-1:0] fps;
    logic [RATE_W-1:0] hz;
    // reset values, stream far below display, equal, unknown display,
    // just below, slowest stream with unknown display
    fps_set = '{60, 1, 240, 240, 59, 1};
    hz_set = '{0, 240, 240, 0, 60, 0};
    idle_set = '{0, 58, 0, 13};
    stall_set = '{0, 0, 58, 13};
    for (int p = 0; p < NUM_PHASES; p++) begin
      // registers only change while nothing is in flight
      wait_results_drained();
      if (p < 6) begin
        fps = RATE_W'(fps_set[p]);
        hz = RATE_W'(hz_set[p]);
      end else begin
        fps = RATE_W'($urandom_range(1, 240));
        hz = RATE_W'($urandom_range(0, 240));
      end
      write_rate_reg(REG_IDX_STREAM_FPS, fps);
      write_rate_reg(REG_IDX_DISPLAY_HZ, hz);
      send_idle_pct = idle_set[p % 4];
      recv_stall_pct = stall_set[p % 4];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 85) begin
          burst = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) :
                                                $urandom_range(0, 4);
          repeat (burst) send_request(CMD_SUBMIT, HANDLE_W'($urandom_range(0, 65535)));
          send_request(CMD_VSYNC, HANDLE_W'($urandom_range(0, 65535)));
          sent += burst + 1;
        end else begin
          send_request($urandom_range(0, 1) ? CMD_VSYNC : CMD_SUBMIT,
                       HANDLE_W'($urandom_range(0, 65535)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.command = CMD_SUBMIT;
    in_if.frame_handle = '0;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_queue();
    test_rate_regimes();
    wait_results_drained();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
